// ----- hdl/mouse_command_text_parser_top_macros.svh -----
// Assertion macros shared by the mouse command text parser RTL.
`ifndef MOUSE_COMMAND_TEXT_PARSER_TOP_MACROS_SVH
`define MOUSE_COMMAND_TEXT_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low
`define MCP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcp: assertion failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low
`define MCP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcp: assertion failed");

`endif

// ----- hdl/mcp_pkg.sv -----
// Types and constants of the mouse command text parser.
package mcp_pkg;

    // Character codes
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_MINUS   = 8'h2d;
    localparam logic [7:0] CHR_R       = 8'h72;
    localparam logic [7:0] CHR_M       = 8'h6d;
    localparam logic [7:0] CHR_X       = 8'h78;
    localparam logic [7:0] CHR_Y       = 8'h79;
    localparam logic [7:0] CHR_L       = 8'h6c;

    // Action codes
    localparam logic [2:0] ACT_MOVE_X         = 3'd0;
    localparam logic [2:0] ACT_MOVE_Y         = 3'd1;
    localparam logic [2:0] ACT_LEFT_PRESS     = 3'd2;
    localparam logic [2:0] ACT_LEFT_RELEASE   = 3'd3;
    localparam logic [2:0] ACT_RIGHT_PRESS    = 3'd4;
    localparam logic [2:0] ACT_RIGHT_RELEASE  = 3'd5;
    localparam logic [2:0] ACT_MIDDLE_PRESS   = 3'd6;
    localparam logic [2:0] ACT_MIDDLE_RELEASE = 3'd7;

    localparam int AMOUNT_BITS = 32;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = 1;

    // Class of a queued character
    typedef enum logic [1:0] {
        CLS_LETTER = 2'd0,
        CLS_MINUS  = 2'd1,
        CLS_DIGIT  = 2'd2,
        CLS_END    = 2'd3
    } char_class_t;

    // One queued entry: class plus the raw byte (digit value sits in the low nibble)
    typedef struct packed {
        char_class_t cls;
        logic [7:0]  chr;
    } item_t;

endpackage

// ----- hdl/mcp_channels.sv -----
// Valid/ready channel interfaces for message bytes and mouse actions.
interface mcp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] char_byte;

    modport source (output valid, output mode, output char_byte, input ready);
    modport sink   (input valid, input mode, input char_byte, output ready);
endinterface

interface mcp_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic signed [31:0] move_amount;

    modport source (output valid, output action, output move_amount, input ready);
    modport sink   (input valid, input action, input move_amount, output ready);
endinterface

// ----- hdl/mcp_front.sv -----
// Front end: accepts message transactions and classifies each byte.
module mcp_front
(
    mcp_in_if.sink          msg,
    output logic            push_valid,
    input  logic            push_ready,
    output mcp_pkg::item_t  push_data
);
    import mcp_pkg::*;

    logic        is_letter;
    logic        is_digit;
    logic        is_minus;
    char_class_t cls;

    // Byte classification
    assign is_letter = ((msg.char_byte >= CHR_UPPER_A) && (msg.char_byte <= CHR_UPPER_Z)) ||
                       ((msg.char_byte >= CHR_LOWER_A) && (msg.char_byte <= CHR_LOWER_Z));
    assign is_digit  = (msg.char_byte >= CHR_ZERO) && (msg.char_byte <= CHR_NINE);
    assign is_minus  = (msg.char_byte == CHR_MINUS);

    always_comb
    begin
        if (msg.mode)
            cls = CLS_END;
        else if (is_letter)
            cls = CLS_LETTER;
        else if (is_minus)
            cls = CLS_MINUS;
        else
            cls = CLS_DIGIT;
    end

    // Ignored bytes are taken and dropped here
    assign msg.ready      = push_ready;
    assign push_valid     = msg.valid && (msg.mode || is_letter || is_digit || is_minus);
    assign push_data.cls  = cls;
    assign push_data.chr  = msg.char_byte;

endmodule

// ----- hdl/mcp_queue.sv -----
// Two-entry queue decoupling the front end from the parser back end.
`include "mouse_command_text_parser_top_macros.svh"

module mcp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mcp_pkg::item_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mcp_pkg::item_t  pop_data
);
    import mcp_pkg::*;

    item_t                     entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic [QUEUE_PTR_BITS:0]   count_next;
    logic                      push_fire;
    logic                      pop_fire;

    assign push_ready = (count_reg < (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (!push_fire && pop_fire)
            count_next = count_reg - 1'b1;
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `MCP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
    `MCP_ASSERT_NXT(a_push_visible, (count_reg == '0) && push_fire, pop_valid)
    `MCP_ASSERT_IMP(a_full_stalls, count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH), !push_ready)

endmodule

// ----- hdl/mcp_back.sv -----
// Back end: name/number parser, action decode and output register.
`include "mouse_command_text_parser_top_macros.svh"

module mcp_back
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  mcp_pkg::item_t  pop_data,
    mcp_out_if.source       act
);
    import mcp_pkg::*;

    localparam int SUM_BITS  = VALUE_BITS + 4;
    localparam int WIDE_BITS = (VALUE_BITS > AMOUNT_BITS) ? VALUE_BITS : AMOUNT_BITS;

    // Parser state
    logic [1:0]            name_len_reg,   name_len_next;
    logic [7:0]            name_a_reg,     name_a_next;
    logic [7:0]            name_b_reg,     name_b_next;
    logic                  present_reg,    present_next;
    logic                  neg_reg,        neg_next;
    logic                  digit_seen_reg, digit_seen_next;
    logic                  stopped_reg,    stopped_next;
    logic [VALUE_BITS-1:0] mag_reg,        mag_next;
    logic                  oor_reg,        oor_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             action_reg;
    logic [AMOUNT_BITS-1:0] amount_reg;

    logic                   pop_fire;
    logic                   out_free;
    logic                   closes;
    logic                   emit;
    logic                   hit;
    logic [2:0]             hit_action;
    logic [VALUE_BITS-1:0]  mag_eff;
    logic [WIDE_BITS-1:0]   mag_wide;
    logic [AMOUNT_BITS-1:0] mag_low;
    logic [AMOUNT_BITS-1:0] amount;
    logic                   nonzero;
    logic [SUM_BITS-1:0]    mag_ext;
    logic [SUM_BITS-1:0]    acc_sum;
    logic [SUM_BITS-1:0]    limit;
    logic [1:0]             len_base;

    // Value of the pending number
    assign mag_eff  = (digit_seen_reg && !oor_reg) ? mag_reg : '0;
    assign nonzero  = (mag_eff != '0);
    assign mag_wide = WIDE_BITS'(mag_eff);
    assign mag_low  = mag_wide[AMOUNT_BITS-1:0];
    assign amount   = neg_reg ? (~mag_low + 1'b1) : mag_low;

    // Name decode
    always_comb
    begin
        hit        = 1'b0;
        hit_action = ACT_MOVE_X;
        if (name_len_reg == 2'd2)
        begin
            unique case ({name_a_reg, name_b_reg})
                {CHR_R, CHR_X}:
                begin
                    hit        = 1'b1;
                    hit_action = ACT_MOVE_X;
                end
                {CHR_R, CHR_Y}:
                begin
                    hit        = 1'b1;
                    hit_action = ACT_MOVE_Y;
                end
                {CHR_M, CHR_L}:
                begin
                    hit        = 1'b1;
                    hit_action = nonzero ? ACT_LEFT_PRESS : ACT_LEFT_RELEASE;
                end
                {CHR_M, CHR_R}:
                begin
                    hit        = 1'b1;
                    hit_action = nonzero ? ACT_RIGHT_PRESS : ACT_RIGHT_RELEASE;
                end
                {CHR_M, CHR_M}:
                begin
                    hit        = 1'b1;
                    hit_action = nonzero ? ACT_MIDDLE_PRESS : ACT_MIDDLE_RELEASE;
                end
                default:
                begin
                    hit        = 1'b0;
                    hit_action = ACT_MOVE_X;
                end
            endcase
        end
    end

    // Handshake: stall only an entry that would emit while the output is held
    assign out_free  = !out_valid_reg || act.ready;
    assign closes    = present_reg &&
                       ((pop_data.cls == CLS_END) || (pop_data.cls == CLS_LETTER));
    assign pop_ready = out_free || !(closes && hit);
    assign pop_fire  = pop_valid && pop_ready;
    assign emit      = pop_fire && closes && hit;

    // Decimal accumulate: mag*10 + d, out of range when above the signed limit
    assign mag_ext = SUM_BITS'(mag_reg);
    assign acc_sum = (mag_ext << 3) + (mag_ext << 1) + SUM_BITS'(pop_data.chr[3:0]);
    assign limit   = neg_reg ? (SUM_BITS'(1) << (VALUE_BITS-1))
                             : ((SUM_BITS'(1) << (VALUE_BITS-1)) - 1'b1);

    // A letter after number text starts a fresh name
    assign len_base = present_reg ? 2'd0 : name_len_reg;

    // Parser next state
    always_comb
    begin
        name_len_next   = name_len_reg;
        name_a_next     = name_a_reg;
        name_b_next     = name_b_reg;
        present_next    = present_reg;
        neg_next        = neg_reg;
        digit_seen_next = digit_seen_reg;
        stopped_next    = stopped_reg;
        mag_next        = mag_reg;
        oor_next        = oor_reg;
        if (pop_fire)
        begin
            unique case (pop_data.cls)
                CLS_END:
                begin
                    name_len_next   = '0;
                    name_a_next     = '0;
                    name_b_next     = '0;
                    present_next    = 1'b0;
                    neg_next        = 1'b0;
                    digit_seen_next = 1'b0;
                    stopped_next    = 1'b0;
                    mag_next        = '0;
                    oor_next        = 1'b0;
                end
                CLS_LETTER:
                begin
                    if (present_reg)
                    begin
                        name_b_next     = '0;
                        present_next    = 1'b0;
                        neg_next        = 1'b0;
                        digit_seen_next = 1'b0;
                        stopped_next    = 1'b0;
                        mag_next        = '0;
                        oor_next        = 1'b0;
                    end
                    if (len_base == 2'd0)
                        name_a_next = pop_data.chr;
                    else if (len_base == 2'd1)
                        name_b_next = pop_data.chr;
                    name_len_next = (len_base == 2'd3) ? len_base : (len_base + 2'd1);
                end
                CLS_MINUS:
                begin
                    if (!present_reg)
                        neg_next = 1'b1;
                    else
                        stopped_next = 1'b1;
                    present_next = 1'b1;
                end
                CLS_DIGIT:
                begin
                    present_next = 1'b1;
                    if (!stopped_reg)
                    begin
                        digit_seen_next = 1'b1;
                        if (!oor_reg)
                        begin
                            if (acc_sum > limit)
                                oor_next = 1'b1;
                            else
                                mag_next = acc_sum[VALUE_BITS-1:0];
                        end
                    end
                end
                default:
                begin
                    present_next = present_reg;
                end
            endcase
        end
    end

    // Output slot
    assign out_valid_next = out_free ? emit : out_valid_reg;

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_len_reg   <= '0;
            name_a_reg     <= '0;
            name_b_reg     <= '0;
            present_reg    <= 1'b0;
            neg_reg        <= 1'b0;
            digit_seen_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            mag_reg        <= '0;
            oor_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            name_len_reg   <= name_len_next;
            name_a_reg     <= name_a_next;
            name_b_reg     <= name_b_next;
            present_reg    <= present_next;
            neg_reg        <= neg_next;
            digit_seen_reg <= digit_seen_next;
            stopped_reg    <= stopped_next;
            mag_reg        <= mag_next;
            oor_reg        <= oor_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            action_reg <= hit_action;
            amount_reg <= ((hit_action == ACT_MOVE_X) || (hit_action == ACT_MOVE_Y))
                          ? amount : '0;
        end
    end

    assign act.valid       = out_valid_reg;
    assign act.action      = action_reg;
    assign act.move_amount = amount_reg;

    `MCP_ASSERT_NXT(a_end_clears, pop_fire && (pop_data.cls == CLS_END), (name_len_reg == 2'd0) && !present_reg)
    `MCP_ASSERT_IMP(a_oor_after_digit, oor_reg, digit_seen_reg && present_reg)
    `MCP_ASSERT_IMP(a_button_no_amount, out_valid_reg && (action_reg >= ACT_LEFT_PRESS), amount_reg == '0)

endmodule

// ----- hdl/mouse_command_text_parser_top.sv -----
// Mouse command text parser: message bytes in, mouse action transactions out.
//
// Channels: msg takes one transaction per byte (mode 0 with char_byte) or an
// end-of-message marker (mode 1). act delivers zero or one action per
// transaction: action code and a signed 32-bit move_amount (zero for buttons).
// A letter after number text, or the end marker, closes a name/number pair;
// only rx, ry, ml, mr and mm produce an action.
// Throughput: one msg transaction per cycle unless act stalls an entry that
// would emit; the back end accumulates digits with a shift-add.
// An action caused by an accepted transaction passes the queue stage, then
// the output register, before act can take it.
// Reset clears the parser state, the queue and the output slot; msg.ready
// is high once the queue is cleared.
// When act stalls, the held action stays in its output register; the back end
// stops only on an entry that would emit, and msg.ready falls once the
// two-entry queue fills.
module mouse_command_text_parser_top
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    mcp_in_if.sink     msg,
    mcp_out_if.source  act
);
    import mcp_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_data;

    mcp_front u_front
    (
        .msg        (msg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mcp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mcp_back
    #(
        .VALUE_BITS (VALUE_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .act       (act)
    );

endmodule
